// ===== design/syringe_pump_step_controller_top_defines.svh =====
// Assertion macros for the syringe pump step controller.
// Used by the top level only; needs clk and rst in scope.
`ifndef SYRINGE_PUMP_STEP_CONTROLLER_TOP_DEFINES_SVH
`define SYRINGE_PUMP_STEP_CONTROLLER_TOP_DEFINES_SVH

// Clocked check, off while reset is high
`define SPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define SPSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/spsc_pkg.sv =====
// Shared types and constants for the syringe pump step controller.
// No dependencies.
package spsc_pkg;

  localparam int COUNT_WIDTH_DEF = 19;
  localparam int DELAY_W    = 20;
  localparam int RATE_W     = 11;
  localparam int VOL_W      = 8;
  localparam int MAXRATE_W  = 10;
  localparam int MAXVOL_W   = 5;
  localparam int HALF_W     = 19;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int STATUS_W   = 2;

  localparam logic [DELAY_W-1:0]   DELAY_NUM_RST = 20'd263671;
  localparam logic [MAXRATE_W-1:0] MAX_RATE_RST  = 10'd1000;
  localparam logic [MAXVOL_W-1:0]  MAX_VOL_RST   = 5'd30;
  localparam logic [DELAY_W-1:0]   PERIOD_RST    = 20'd10000;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REJECT  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RUNNING = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                running;
    logic                step_level;
    logic                direction;
    logic [DELAY_W-1:0]  delay_us;
    logic [HALF_W-1:0]   half_steps;
  } result_t;

endpackage

// ===== design/spsc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on spsc_pkg for operand widths.
module spsc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [spsc_pkg::DELAY_W-1:0] dividend,
  input  logic [spsc_pkg::RATE_W-1:0]  divisor,
  output logic                         done,
  output logic [spsc_pkg::DELAY_W-1:0] quotient
);
  import spsc_pkg::*;

  localparam int STEP_W = $clog2(DELAY_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DELAY_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [RATE_W-1:0] rem;
  logic [RATE_W-1:0] dsr;
  logic [DELAY_W-1:0] quo;

  logic [RATE_W:0] shifted;
  logic [RATE_W:0] diff;
  logic            ge;

  // remainder stays below the divisor, so it always fits RATE_W bits
  always_comb begin
    shifted = {rem, quo[DELAY_W-1]};
    diff    = shifted - {1'b0, dsr};
    ge      = ~diff[RATE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DELAY_W-2:0], ge};
      rem <= ge ? diff[RATE_W-1:0] : shifted[RATE_W-1:0];
    end
  end

  assign quotient = quo;

endmodule

// ===== design/syringe_pump_step_controller_top.sv =====
// Syringe pump step controller: tick, start and stop commands drive a step pin.
// Tick, stop, rejected start: result next cycle; one beat a cycle if the queue has room.
// Accepted start: result from the 20-step serial divider, queued once it is done.
// Input is held off meanwhile, so the next beat waits until the divide is done.
// A two-entry result queue lets input beats continue while a result waits.
// Reset (synchronous, rst high): stopped, phase high-next, period 10000, registers default.
`include "syringe_pump_step_controller_top_defines.svh"

module syringe_pump_step_controller_top #(
  parameter int COUNT_WIDTH = spsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [spsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spsc_pkg::CFG_W-1:0]     cfg_data,
  // command beats
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // rate[10:0], volume[18:11], zero pad
  input  logic [1:0]                     s_tuser,  // cmd[1:0]
  // result beats
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // running[0], step_level[1], direction[2], delay_us[22:3], half_steps[41:23], zero pad
  output logic [47:0]                    m_tdata,
  output logic [1:0]                     m_tuser   // status[1:0]
);
  import spsc_pkg::*;

  // configuration
  logic [DELAY_W-1:0]   delay_numerator;
  logic [MAXRATE_W-1:0] max_rate;
  logic [MAXVOL_W-1:0]  max_volume;

  // pump state
  logic                   run_flag;
  logic                   phase;
  logic                   dir_level;
  logic [COUNT_WIDTH-1:0] step_count;
  logic [MAXVOL_W-1:0]    target_ml;
  logic [DELAY_W-1:0]     period_us;
  state_t                 state;
  state_t                 state_next;

  // latched start request while dividing
  logic                   pend_dir;
  logic [MAXVOL_W-1:0]    pend_ml;

  // result queue
  result_t     rq_mem [2];
  logic        rq_wr;
  logic        rq_rd;
  logic [1:0]  rq_cnt;
  logic        push;
  logic        pop;
  result_t     push_res;

  // divider
  logic               div_start;
  logic               div_done;
  logic [DELAY_W-1:0] div_q;

  // input decode
  cmd_t              cmd;
  logic [RATE_W-1:0] rate;
  logic [VOL_W-1:0]  volume;
  logic              neg;
  logic [RATE_W-1:0] mag;
  logic              in_range;
  logic              acc;
  logic              start_go;

  logic                   run_next;
  logic                   phase_next;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH+1:0] count_x3;
  logic [20:0]            thr21;
  logic [COUNT_WIDTH+1:0] thr;
  logic [STATUS_W-1:0]    status_imm;

  assign cmd    = cmd_t'(s_tuser);
  assign rate   = s_tdata[RATE_W-1:0];
  assign volume = s_tdata[RATE_W+VOL_W-1:RATE_W];
  assign acc    = s_tvalid && s_tready;

  always_comb begin
    neg      = rate[RATE_W-1];
    mag      = neg ? (~rate + RATE_W'(1)) : rate;
    in_range = (mag != '0) && (mag <= {1'b0, max_rate}) &&
               (volume != '0) && (volume <= {3'b0, max_volume});
  end

  // tick arithmetic: stop once 3*count > 40960*target
  always_comb begin
    count_inc = (step_count == {COUNT_WIDTH{1'b1}}) ? step_count
                                                    : step_count + COUNT_WIDTH'(1);
    count_x3  = ({2'b0, count_inc} << 1) + {2'b0, count_inc};
    thr21     = {1'b0, target_ml, 15'b0} + {3'b0, target_ml, 13'b0};
    thr       = (COUNT_WIDTH+2)'(thr21);
  end

  always_comb begin
    run_next   = run_flag;
    phase_next = phase;
    count_next = step_count;
    status_imm = STAT_OK;
    start_go   = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (run_flag) begin
          phase_next = ~phase;
          count_next = count_inc;
          if (count_x3 > thr) begin
            run_next = 1'b0;
          end
        end
      end
      CMD_START: begin
        if (run_flag) begin
          status_imm = STAT_RUNNING;
        end else if (in_range) begin
          start_go = 1'b1;
        end else begin
          status_imm = STAT_REJECT;
        end
      end
      CMD_STOP: begin
        run_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && start_go) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = (state == ST_IDLE) && (rq_cnt != 2'd2);
    div_start = 1'b0;
    case (state)
      ST_IDLE: div_start = acc && start_go;
      default: div_start = 1'b0;
    endcase
  end

  spsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delay_numerator),
    .divisor  (mag),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    push = div_done || (acc && !start_go);
    pop  = m_tvalid && m_tready;
    if (div_done) begin
      push_res.status     = STAT_OK;
      push_res.running    = 1'b1;
      push_res.step_level = ~phase;
      push_res.direction  = pend_dir;
      push_res.delay_us   = div_q;
      push_res.half_steps = '0;
    end else begin
      push_res.status     = status_imm;
      push_res.running    = run_next;
      push_res.step_level = ~phase_next;
      push_res.direction  = dir_level;
      push_res.delay_us   = period_us;
      push_res.half_steps = count_next[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_numerator <= DELAY_NUM_RST;
      max_rate        <= MAX_RATE_RST;
      max_volume      <= MAX_VOL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_NUM:  delay_numerator <= cfg_data[DELAY_W-1:0];
        REG_MAX_RATE:   max_rate        <= cfg_data[MAXRATE_W-1:0];
        REG_MAX_VOLUME: max_volume      <= cfg_data[MAXVOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      run_flag   <= 1'b0;
      phase      <= 1'b1;
      dir_level  <= 1'b0;
      step_count <= '0;
      target_ml  <= '0;
      period_us  <= PERIOD_RST;
      pend_dir   <= 1'b0;
      pend_ml    <= '0;
    end else begin
      state <= state_next;
      if (div_start) begin
        pend_dir <= ~neg;
        pend_ml  <= volume[MAXVOL_W-1:0];
      end
      if (div_done) begin
        run_flag   <= 1'b1;
        dir_level  <= pend_dir;
        step_count <= '0;
        target_ml  <= pend_ml;
        period_us  <= div_q;
      end else if (acc) begin
        run_flag   <= run_next;
        phase      <= phase_next;
        step_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr  <= 1'b0;
      rq_rd  <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (push) begin
        rq_wr <= ~rq_wr;
      end
      if (pop) begin
        rq_rd <= ~rq_rd;
      end
      case ({push, pop})
        2'b10:   rq_cnt <= rq_cnt + 2'd1;
        2'b01:   rq_cnt <= rq_cnt - 2'd1;
        default: rq_cnt <= rq_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      rq_mem[rq_wr] <= push_res;
    end
  end

  assign m_tvalid = (rq_cnt != 2'd0);
  assign m_tuser  = rq_mem[rq_rd].status;
  assign m_tdata  = {6'b0,
                     rq_mem[rq_rd].half_steps,
                     rq_mem[rq_rd].delay_us,
                     rq_mem[rq_rd].direction,
                     rq_mem[rq_rd].step_level,
                     rq_mem[rq_rd].running};

  `SPSC_ASSERT(a_done_in_div, div_done |-> (state == ST_DIV), "divider done outside divide")
  `SPSC_ASSERT(a_div_stopped, (state == ST_DIV) |-> !run_flag, "dividing while running")
  `SPSC_ASSERT(a_period_hold, !div_done |=> $stable(period_us), "period moved without start")
  `SPSC_ASSERT_ALWAYS(a_rq_bound, rst || (rq_cnt != 2'd3), "result queue overflow")

endmodule
